### rtl/bfiq_pkg.sv
// Shared constants, types and sine/cosine lookup for the boxcar filter
// and I/Q demodulator. No dependencies.
package bfiq_pkg;

  // Filter lengths
  localparam int HP_LEN  = 50;
  localparam int LP1_LEN = 32;
  localparam int LP2_LEN = 16;

  localparam int SAMPLE_W = 16;
  localparam int FILT_W   = 32;
  localparam int ACC_W    = 64;

  // Delay-line geometry
  localparam int HP_PTR_W  = $clog2(HP_LEN);
  localparam int LP1_PTR_W = $clog2(LP1_LEN);
  localparam int LP2_PTR_W = $clog2(LP2_LEN);
  // Delay tap sits HP_LEN/2 + 1 past the write slot
  localparam int HP_RD_OFS = HP_LEN / 2 + 1;

  // Exact widths of the running sums
  localparam int HP_SUM_W    = SAMPLE_W + $clog2(HP_LEN);
  localparam int HP_OUT_W    = HP_SUM_W + 1;
  localparam int LP1_SUM_W   = HP_OUT_W + $clog2(LP1_LEN);
  localparam int LP2_EXACT_W = LP1_SUM_W + $clog2(LP2_LEN);
  localparam int LP2_SUM_W   = (LP2_EXACT_W > FILT_W) ? LP2_EXACT_W : FILT_W;

  // Demodulator
  localparam int START_W          = 10;
  localparam logic [START_W-1:0] DEMOD_START_RST = 10'd50;
  localparam logic [START_W-1:0] KEPT_MAX        = 10'd1023;
  localparam int STEP_W   = 16;
  localparam int PHASE_W  = 7;
  localparam int PERIOD   = 100;
  localparam int QUARTER  = 25;
  localparam int PHASE_INC = 2;
  localparam int DIV_SHIFT = 11;  // product / 2048

  // Result queue
  localparam int OUTQ_DEPTH = 16;
  localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
  localparam int OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

  typedef struct packed {
    logic signed [FILT_W-1:0] filtered;
    logic signed [ACC_W-1:0]  acc_in_phase;
    logic signed [ACC_W-1:0]  acc_quadrature;
    logic                     demod_active;
  } result_t;

  // Q31 quarter wave, 26 points
  localparam logic [31:0] QWAVE [26] = '{
    32'd0,          32'd134841613,  32'd269151069,  32'd402398308,
    32'd534057465,  32'd663608942,  32'd790541456,  32'd914354065,
    32'd1034558137, 32'd1150679279, 32'd1262259217, 32'd1368857594,
    32'd1470053715, 32'd1565448206, 32'd1654664588, 32'd1737350765,
    32'd1813180412, 32'd1881854265, 32'd1943101298, 32'd1996679798,
    32'd2042378316, 32'd2080016499, 32'd2109445807, 32'd2130550097,
    32'd2143246078, 32'd2147483647
  };

  function automatic logic signed [31:0] sin_q31(logic [PHASE_W-1:0] p);
    logic [PHASE_W-1:0] idx;
    logic               neg;
    if (p < PHASE_W'(QUARTER)) begin
      idx = p;
      neg = 1'b0;
    end else if (p < PHASE_W'(2 * QUARTER)) begin
      idx = PHASE_W'(2 * QUARTER) - p;
      neg = 1'b0;
    end else if (p < PHASE_W'(3 * QUARTER)) begin
      idx = p - PHASE_W'(2 * QUARTER);
      neg = 1'b1;
    end else begin
      idx = PHASE_W'(PERIOD) - p;
      neg = 1'b1;
    end
    return neg ? -$signed(QWAVE[idx[4:0]]) : $signed(QWAVE[idx[4:0]]);
  endfunction

  function automatic logic signed [31:0] cos_q31(logic [PHASE_W-1:0] p);
    logic [PHASE_W-1:0] idx;
    logic               neg;
    if (p < PHASE_W'(QUARTER)) begin
      idx = PHASE_W'(QUARTER) - p;
      neg = 1'b0;
    end else if (p < PHASE_W'(2 * QUARTER)) begin
      idx = p - PHASE_W'(QUARTER);
      neg = 1'b1;
    end else if (p < PHASE_W'(3 * QUARTER)) begin
      idx = PHASE_W'(3 * QUARTER) - p;
      neg = 1'b1;
    end else begin
      idx = p - PHASE_W'(3 * QUARTER);
      neg = 1'b0;
    end
    return neg ? -$signed(QWAVE[idx[4:0]]) : $signed(QWAVE[idx[4:0]]);
  endfunction

endpackage

### rtl/bfiq_front.sv
// Front end: decimation by two and a two-entry queue of kept samples.
// Depends on bfiq_pkg.
module bfiq_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [bfiq_pkg::SAMPLE_W-1:0] sample_i,
  input  logic                          pop_i,
  output logic                          q_valid_o,
  output logic [bfiq_pkg::SAMPLE_W-1:0] q_sample_o
);
  import bfiq_pkg::*;

  logic                toggle_q;
  logic [SAMPLE_W-1:0] q_mem_q [2];
  logic                q_wr_q, q_rd_q;
  logic [1:0]          q_cnt_q, q_cnt_d;
  logic                accept, push;

  // odd beats are dropped, so they never need queue room
  assign in_ready_o = toggle_q | (q_cnt_q != 2'd2);
  assign accept     = in_valid_i & in_ready_o;
  assign push       = accept & ~toggle_q;
  assign q_valid_o  = (q_cnt_q != 2'd0);
  assign q_sample_o = q_mem_q[q_rd_q];

  always_comb begin
    q_cnt_d = q_cnt_q;
    case ({push, pop_i})
      2'b10:   q_cnt_d = q_cnt_q + 2'd1;
      2'b01:   q_cnt_d = q_cnt_q - 2'd1;
      default: q_cnt_d = q_cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      toggle_q <= 1'b0;
      q_wr_q   <= 1'b0;
      q_rd_q   <= 1'b0;
      q_cnt_q  <= 2'd0;
    end else begin
      if (accept) toggle_q <= ~toggle_q;
      if (push) q_wr_q <= ~q_wr_q;
      if (pop_i) q_rd_q <= ~q_rd_q;
      q_cnt_q <= q_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) q_mem_q[q_wr_q] <= sample_i;
  end

endmodule

### rtl/bfiq_filter.sv
// Back end filter chain: boxcar high-pass, then two boxcar sums.
// Four-stage fixed-latency pipeline, no stall. Depends on bfiq_pkg.
module bfiq_filter (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [bfiq_pkg::SAMPLE_W-1:0]     sample_i,
  output logic                              valid_o,
  output logic signed [bfiq_pkg::FILT_W-1:0] filtered_o
);
  import bfiq_pkg::*;

  // delay lines; entries not yet written read as zero via the wrap flags
  logic [SAMPLE_W-1:0]         hp_mem  [HP_LEN];
  logic signed [HP_OUT_W-1:0]  lp1_mem [LP1_LEN];
  logic signed [LP1_SUM_W-1:0] lp2_mem [LP2_LEN];

  // high-pass pointers
  logic [HP_PTR_W-1:0] hp_ptr_q, hp_rd;
  logic [HP_PTR_W:0]   hp_rd_sum;
  logic                hp_wrap_q;

  // stage 1
  logic                s1_v_q;
  logic [SAMPLE_W-1:0] s1_x_q, s1_old_raw_q, s1_dly_raw_q;
  logic                s1_old_ok_q, s1_dly_ok_q;
  logic [SAMPLE_W-1:0] s1_old, s1_dly;
  logic [HP_SUM_W-1:0] hp_sum_q, hp_sum_d;

  // stage 2
  logic                       s2_v_q;
  logic [HP_SUM_W-1:0]        s2_sum_q, s2_scaled_q;
  logic signed [HP_OUT_W-1:0] s2_lp1_raw_q, lp1_old, hp_out;
  logic                       s2_lp1_ok_q;
  logic [LP1_PTR_W-1:0]       lp1_rd_q, lp1_wr_q;
  logic                       lp1_rwrap_q;
  logic signed [LP1_SUM_W-1:0] lp1_sum_q, lp1_sum_d;

  // stage 3
  logic                        s3_v_q;
  logic signed [LP1_SUM_W-1:0] s3_lp1_q, s3_lp2_raw_q, lp2_old;
  logic                        s3_lp2_ok_q;
  logic [LP2_PTR_W-1:0]        lp2_rd_q, lp2_wr_q;
  logic                        lp2_rwrap_q;
  logic signed [LP2_SUM_W-1:0] lp2_sum_q, lp2_sum_d;

  // stage 4
  logic                     s4_v_q;
  logic signed [FILT_W-1:0] s4_filt_q;

  assign hp_rd_sum = {1'b0, hp_ptr_q} + (HP_PTR_W + 1)'(HP_RD_OFS);
  assign hp_rd     = (hp_rd_sum >= (HP_PTR_W + 1)'(HP_LEN))
                     ? HP_PTR_W'(hp_rd_sum - (HP_PTR_W + 1)'(HP_LEN))
                     : HP_PTR_W'(hp_rd_sum);

  assign s1_old   = s1_old_ok_q ? s1_old_raw_q : '0;
  assign s1_dly   = s1_dly_ok_q ? s1_dly_raw_q : '0;
  assign hp_sum_d = hp_sum_q + HP_SUM_W'(s1_x_q) - HP_SUM_W'(s1_old);

  assign hp_out    = $signed({1'b0, s2_scaled_q}) - $signed({1'b0, s2_sum_q});
  assign lp1_old   = s2_lp1_ok_q ? s2_lp1_raw_q : '0;
  assign lp1_sum_d = lp1_sum_q + LP1_SUM_W'(hp_out) - LP1_SUM_W'(lp1_old);

  assign lp2_old   = s3_lp2_ok_q ? s3_lp2_raw_q : '0;
  assign lp2_sum_d = lp2_sum_q + LP2_SUM_W'(s3_lp1_q) - LP2_SUM_W'(lp2_old);

  assign valid_o    = s4_v_q;
  assign filtered_o = s4_filt_q;

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q      <= 1'b0;
      s2_v_q      <= 1'b0;
      s3_v_q      <= 1'b0;
      s4_v_q      <= 1'b0;
      hp_ptr_q    <= '0;
      hp_wrap_q   <= 1'b0;
      hp_sum_q    <= '0;
      lp1_rd_q    <= '0;
      lp1_wr_q    <= '0;
      lp1_rwrap_q <= 1'b0;
      lp1_sum_q   <= '0;
      lp2_rd_q    <= '0;
      lp2_wr_q    <= '0;
      lp2_rwrap_q <= 1'b0;
      lp2_sum_q   <= '0;
    end else begin
      s1_v_q <= start_i;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
      s4_v_q <= s3_v_q;
      if (start_i) begin
        if (hp_ptr_q == HP_PTR_W'(HP_LEN - 1)) begin
          hp_ptr_q  <= '0;
          hp_wrap_q <= 1'b1;
        end else begin
          hp_ptr_q <= hp_ptr_q + 1'b1;
        end
      end
      if (s1_v_q) begin
        hp_sum_q <= hp_sum_d;
        if (lp1_rd_q == LP1_PTR_W'(LP1_LEN - 1)) begin
          lp1_rd_q    <= '0;
          lp1_rwrap_q <= 1'b1;
        end else begin
          lp1_rd_q <= lp1_rd_q + 1'b1;
        end
      end
      if (s2_v_q) begin
        lp1_sum_q <= lp1_sum_d;
        lp1_wr_q  <= (lp1_wr_q == LP1_PTR_W'(LP1_LEN - 1)) ? '0 : lp1_wr_q + 1'b1;
        if (lp2_rd_q == LP2_PTR_W'(LP2_LEN - 1)) begin
          lp2_rd_q    <= '0;
          lp2_rwrap_q <= 1'b1;
        end else begin
          lp2_rd_q <= lp2_rd_q + 1'b1;
        end
      end
      if (s3_v_q) begin
        lp2_sum_q <= lp2_sum_d;
        lp2_wr_q  <= (lp2_wr_q == LP2_PTR_W'(LP2_LEN - 1)) ? '0 : lp2_wr_q + 1'b1;
      end
    end
  end

  // payload and delay-line memories
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      s1_x_q       <= sample_i;
      s1_old_ok_q  <= hp_wrap_q;
      s1_dly_ok_q  <= hp_wrap_q | (hp_rd < hp_ptr_q);
      s1_old_raw_q <= hp_mem[hp_ptr_q];
      s1_dly_raw_q <= hp_mem[hp_rd];
      hp_mem[hp_ptr_q] <= sample_i;
    end
    if (s1_v_q) begin
      s2_sum_q     <= hp_sum_d;
      s2_scaled_q  <= HP_SUM_W'(HP_LEN) * HP_SUM_W'(s1_dly);
      s2_lp1_ok_q  <= lp1_rwrap_q;
      s2_lp1_raw_q <= lp1_mem[lp1_rd_q];
    end
    if (s2_v_q) begin
      lp1_mem[lp1_wr_q] <= hp_out;
      s3_lp1_q     <= lp1_sum_d;
      s3_lp2_ok_q  <= lp2_rwrap_q;
      s3_lp2_raw_q <= lp2_mem[lp2_rd_q];
    end
    if (s3_v_q) begin
      lp2_mem[lp2_wr_q] <= s3_lp1_q;
      s4_filt_q <= lp2_sum_d[FILT_W-1:0];
    end
  end

endmodule

### rtl/bfiq_demod.sv
// Back end demodulator: phase tracking, sine/cosine weighting, /2048
// toward zero and 64-bit I/Q accumulation. Depends on bfiq_pkg.
module bfiq_demod (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               valid_i,
  input  logic signed [bfiq_pkg::FILT_W-1:0] filtered_i,
  input  logic [bfiq_pkg::START_W-1:0]       demod_start_i,
  output logic                               valid_o,
  output bfiq_pkg::result_t                  result_o
);
  import bfiq_pkg::*;

  logic [START_W-1:0] kept_q;
  logic [STEP_W-1:0]  step_q, step_d;
  logic [PHASE_W-1:0] phase_q, phase_sum;
  logic               act;

  logic                     d1_v_q, d1_act_q;
  logic signed [31:0]       d1_sin_q, d1_cos_q;
  logic signed [FILT_W-1:0] d1_val_q;

  logic                     d2_v_q, d2_act_q;
  logic signed [ACC_W-1:0]  d2_pi_q, d2_pq_q;
  logic signed [FILT_W-1:0] d2_filt_q;
  logic signed [ACC_W-1:0]  pi_adj, pq_adj;

  logic                     d3_v_q, d3_act_q;
  logic signed [ACC_W-1:0]  d3_qi_q, d3_qq_q;
  logic signed [FILT_W-1:0] d3_filt_q;

  logic signed [ACC_W-1:0] acc_i_q, acc_q_q, acc_i_d, acc_q_d;
  logic                    res_v_q;
  result_t                 res_q;

  assign act       = (kept_q >= demod_start_i);
  assign step_d    = step_q + 1'b1;
  assign phase_sum = phase_q + PHASE_W'(PHASE_INC);

  // round toward zero: bias negative products before the arithmetic shift
  assign pi_adj = d2_pi_q + ACC_W'({DIV_SHIFT{d2_pi_q[ACC_W-1]}});
  assign pq_adj = d2_pq_q + ACC_W'({DIV_SHIFT{d2_pq_q[ACC_W-1]}});

  assign acc_i_d = d3_act_q ? acc_i_q + d3_qi_q : acc_i_q;
  assign acc_q_d = d3_act_q ? acc_q_q + d3_qq_q : acc_q_q;

  assign valid_o  = res_v_q;
  assign result_o = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kept_q  <= '0;
      step_q  <= '0;
      phase_q <= '0;
      d1_v_q  <= 1'b0;
      d2_v_q  <= 1'b0;
      d3_v_q  <= 1'b0;
      res_v_q <= 1'b0;
      acc_i_q <= '0;
      acc_q_q <= '0;
    end else begin
      d1_v_q  <= valid_i;
      d2_v_q  <= d1_v_q;
      d3_v_q  <= d2_v_q;
      res_v_q <= d3_v_q;
      if (valid_i) begin
        if (kept_q != KEPT_MAX) kept_q <= kept_q + 1'b1;
        if (act) begin
          step_q <= step_d;
          // phase restarts together with the step counter
          if (step_d == '0) phase_q <= '0;
          else if (phase_sum >= PHASE_W'(PERIOD)) phase_q <= phase_sum - PHASE_W'(PERIOD);
          else phase_q <= phase_sum;
        end
      end
      if (d3_v_q) begin
        acc_i_q <= acc_i_d;
        acc_q_q <= acc_q_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      d1_act_q <= act;
      d1_sin_q <= sin_q31(phase_q);
      d1_cos_q <= cos_q31(phase_q);
      d1_val_q <= filtered_i;
    end
    if (d1_v_q) begin
      d2_act_q  <= d1_act_q;
      d2_pi_q   <= ACC_W'(d1_sin_q) * ACC_W'(d1_val_q);
      d2_pq_q   <= ACC_W'(d1_cos_q) * ACC_W'(d1_val_q);
      d2_filt_q <= d1_val_q;
    end
    if (d2_v_q) begin
      d3_act_q  <= d2_act_q;
      d3_qi_q   <= pi_adj >>> DIV_SHIFT;
      d3_qq_q   <= pq_adj >>> DIV_SHIFT;
      d3_filt_q <= d2_filt_q;
    end
    if (d3_v_q) begin
      res_q.filtered       <= d3_filt_q;
      res_q.acc_in_phase   <= acc_i_d;
      res_q.acc_quadrature <= acc_q_d;
      res_q.demod_active   <= d3_act_q;
    end
  end

endmodule

### rtl/bfiq_outq.sv
// Result queue with slot reservation: a sample enters the back end only
// when a slot is held for its result. Depends on bfiq_pkg.
module bfiq_outq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              reserve_i,
  output logic              space_o,
  input  logic              push_i,
  input  bfiq_pkg::result_t push_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output bfiq_pkg::result_t out_data_o
);
  import bfiq_pkg::*;

  result_t               mem_q [OUTQ_DEPTH];
  logic [OUTQ_PTR_W-1:0] wr_q, rd_q;
  logic [OUTQ_CNT_W-1:0] cnt_q, resv_q;
  logic                  pop;

  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = mem_q[rd_q];
  assign pop         = out_valid_o & out_ready_i;
  // reservations cover results in flight plus those stored
  assign space_o     = (resv_q != OUTQ_CNT_W'(OUTQ_DEPTH));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= '0;
      rd_q   <= '0;
      cnt_q  <= '0;
      resv_q <= '0;
    end else begin
      if (push_i) wr_q <= (wr_q == OUTQ_PTR_W'(OUTQ_DEPTH - 1)) ? '0 : wr_q + 1'b1;
      if (pop) rd_q <= (rd_q == OUTQ_PTR_W'(OUTQ_DEPTH - 1)) ? '0 : rd_q + 1'b1;
      cnt_q  <= cnt_q + OUTQ_CNT_W'(push_i) - OUTQ_CNT_W'(pop);
      resv_q <= resv_q + OUTQ_CNT_W'(reserve_i) - OUTQ_CNT_W'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_data_i;
  end

endmodule

### rtl/boxcar_filter_iq_demodulator.sv
// Boxcar filter chain with I/Q lock-in demodulation, top level.
// Depends on bfiq_pkg, bfiq_front, bfiq_filter, bfiq_demod, bfiq_outq.
//
// Takes one raw sample beat per clock while in_ready is high; every
// second beat after reset is dropped and yields no result, and each kept
// sample yields one result beat (filtered value, I/Q accumulators after
// it, active flag). Sustained rate is one input beat per cycle while the
// output drains. Kept samples pass the front queue, the 4-stage filter
// pipeline (delay-line memory reads, then running sums) and the 4-stage
// demodulator (table lookup, 32x32 multiply, rounding, accumulate).
// A 16-entry result queue absorbs output stalls; input is held off only
// once all 16 slots are taken and the two-entry front queue has filled.
// Delay lines read as zero until first written, so no clearing pass
// follows reset. demod_start resets to 50 and should be written only
// while the block is idle.
module boxcar_filter_iq_demodulator (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [bfiq_pkg::START_W-1:0]        cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [bfiq_pkg::SAMPLE_W-1:0]       sample_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [bfiq_pkg::FILT_W-1:0]  filtered_o,
  output logic signed [bfiq_pkg::ACC_W-1:0]   acc_in_phase_o,
  output logic signed [bfiq_pkg::ACC_W-1:0]   acc_quadrature_o,
  output logic                                demod_active_o
);
  import bfiq_pkg::*;

  logic [START_W-1:0]       demod_start_q;
  logic                     q_valid, space, start;
  logic [SAMPLE_W-1:0]      q_sample;
  logic                     filt_v, res_v;
  logic signed [FILT_W-1:0] filt;
  result_t                  res, out_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      demod_start_q <= DEMOD_START_RST;
    end else if (cfg_we_i) begin
      demod_start_q <= cfg_wdata_i;
    end
  end

  assign start = q_valid & space;

  bfiq_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sample_i   (sample_i),
    .pop_i      (start),
    .q_valid_o  (q_valid),
    .q_sample_o (q_sample)
  );

  bfiq_filter u_filter (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .sample_i   (q_sample),
    .valid_o    (filt_v),
    .filtered_o (filt)
  );

  bfiq_demod u_demod (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (filt_v),
    .filtered_i    (filt),
    .demod_start_i (demod_start_q),
    .valid_o       (res_v),
    .result_o      (res)
  );

  bfiq_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .reserve_i   (start),
    .space_o     (space),
    .push_i      (res_v),
    .push_data_i (res),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data)
  );

  assign filtered_o       = out_data.filtered;
  assign acc_in_phase_o   = out_data.acc_in_phase;
  assign acc_quadrature_o = out_data.acc_quadrature;
  assign demod_active_o   = out_data.demod_active;

endmodule
